// File: hdl/nearest_center_search_top_defines.svh
// assertion macros used by the checker file
`ifndef NEAREST_CENTER_SEARCH_TOP_DEFINES_SVH
`define NEAREST_CENTER_SEARCH_TOP_DEFINES_SVH

// clocked assertion, off while reset is low
`define NCS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define NCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ncs_pkg.sv
`timescale 1ns / 1ps

package ncs_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int COORD_BITS_DEF  = 20;

    localparam int LIMIT_W   = 42;
    localparam int COUNT_W   = 8;
    localparam int OUT_IDX_W = 7;
    localparam int ENTRY_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 42'd1400000;
    localparam logic [COUNT_W-1:0] CELLS_RESET = 8'd91;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_DISTANCE_LIMIT = 2'd0,
        CFG_CELLS_IN_USE   = 2'd1
    } cfg_reg_t;

    // control that travels with each scan step through the distance pipeline
    typedef struct packed
    {
        logic live;
        logic first;
        logic in_range;
        logic last;
    } scan_ctrl_t;

endpackage

// File: hdl/ncs_if.sv
`timescale 1ns / 1ps

interface ncs_in_if #(
    parameter int COORD_BITS = ncs_pkg::COORD_BITS_DEF
);
    import ncs_pkg::*;

    logic                         valid;
    logic                         ready;
    cmd_t                         command;
    logic [ENTRY_W-1:0]           entry_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, output command, output entry_index, output coord_x,
                    output coord_y, input ready);
    modport sink (input valid, input command, input entry_index, input coord_x,
                  input coord_y, output ready);
endinterface

interface ncs_out_if;
    import ncs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] nearest_index;
    logic                 found;

    modport source (output valid, output nearest_index, output found, input ready);
    modport sink (input valid, input nearest_index, input found, output ready);
endinterface

interface ncs_cfg_if;
    import ncs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LIMIT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/ncs_cell.sv
`timescale 1ns / 1ps

module ncs_cell #(
    parameter int COORD_BITS = ncs_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         shift,
    input  logic signed [COORD_BITS-1:0] load_x,
    input  logic signed [COORD_BITS-1:0] load_y,
    input  logic signed [COORD_BITS-1:0] nbr_x,
    input  logic signed [COORD_BITS-1:0] nbr_y,
    output logic signed [COORD_BITS-1:0] x,
    output logic signed [COORD_BITS-1:0] y
);
    import ncs_pkg::*;

    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] x_next;
    logic signed [COORD_BITS-1:0] y_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (load)
        begin
            x_next = load_x;
            y_next = load_y;
        end
        else if (shift)
        begin
            x_next = nbr_x;
            y_next = nbr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

// File: hdl/ncs_dist.sv
`timescale 1ns / 1ps

module ncs_dist #(
    parameter int COORD_BITS = ncs_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ncs_pkg::scan_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]             idx,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic [ncs_pkg::LIMIT_W-1:0]  limit,
    output logic                         done,
    output logic [IDX_W-1:0]             best_idx,
    output logic                         found
);
    import ncs_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int DIST_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    scan_ctrl_t               s1_ctrl_reg;
    scan_ctrl_t               s2_ctrl_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [2*DIFF_W-1:0] prod_x;
    logic signed [2*DIFF_W-1:0] prod_y;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [SUM_W-1:0]         sum;
    logic [DIST_W-1:0]        base_dist;
    logic [IDX_W-1:0]         base_idx;
    logic                     base_found;
    logic                     hit;
    logic [DIST_W-1:0]        best_dist_reg;
    logic [DIST_W-1:0]        best_dist_next;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [IDX_W-1:0]         best_idx_next;
    logic                     found_reg;
    logic                     found_next;
    logic                     done_reg;

    // stage 1: coordinate differences
    assign dx_next = $signed({cx[COORD_BITS-1], cx}) - $signed({px[COORD_BITS-1], px});
    assign dy_next = $signed({cy[COORD_BITS-1], cy}) - $signed({py[COORD_BITS-1], py});

    // stage 2: squares
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    // stage 3: sum and running minimum
    always_comb
    begin
        sum        = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        base_dist  = s2_ctrl_reg.first ? DIST_W'(limit) : best_dist_reg;
        base_idx   = s2_ctrl_reg.first ? '0 : best_idx_reg;
        base_found = s2_ctrl_reg.first ? 1'b0 : found_reg;
        hit        = s2_ctrl_reg.in_range && (DIST_W'(sum) < base_dist);
        best_dist_next = hit ? DIST_W'(sum) : base_dist;
        best_idx_next  = hit ? s2_idx_reg : base_idx;
        found_next     = hit | base_found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg <= ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
            done_reg    <= s2_ctrl_reg.live && s2_ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= idx;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        s2_idx_reg <= s1_idx_reg;
        sqx_reg    <= prod_x[SQ_W-1:0];
        sqy_reg    <= prod_y[SQ_W-1:0];
        if (s2_ctrl_reg.live)
        begin
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
        end
    end

    assign done     = done_reg;
    assign best_idx = best_idx_reg;
    assign found    = found_reg;

endmodule

// File: hdl/nearest_center_search_top.sv
`timescale 1ns / 1ps

// channel | dir | payload                                    | transaction
// item    | in  | command, entry_index, coord_x, coord_y     | valid & ready
// result  | out | nearest_index, found                       | valid & ready
// cfg     | in  | index, data                                | valid & ready
//
// a load writes its cell when taken; a query scans every cell, waits for the distance pipeline,
// then loads the result register once that register is free; the next item is taken in idle
// the centers sit in a ring of cells that rotates once per query into one distance pipeline
// item.ready is high only while no query is in flight; cfg.ready is always high
// a finished result waits in the output register while the next item is taken
// reset clears control state only; table entries hold garbage until loaded

module nearest_center_search_top #(
    parameter int TABLE_DEPTH = ncs_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = ncs_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ncs_in_if.sink     item,
    ncs_out_if.source  result,
    ncs_cfg_if.sink    cfg
);
    import ncs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_PUSH = 4'b1000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [IDX_W-1:0]             step_reg;
    logic [IDX_W-1:0]             step_next;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [LIMIT_W-1:0]           limit_reg;
    logic [COUNT_W-1:0]           cells_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OUT_IDX_W-1:0]         out_idx_reg;
    logic                         out_found_reg;
    logic                         item_accept;
    logic                         query_start;
    logic                         load_ok;
    logic                         shift;
    logic                         push;
    scan_ctrl_t                   ctrl;
    logic                         dist_done;
    logic [IDX_W-1:0]             best_idx;
    logic                         best_found;

    logic signed [COORD_BITS-1:0] cell_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] cell_y [TABLE_DEPTH];

    assign item.ready   = (state_reg == S_IDLE);
    assign item_accept  = item.valid && item.ready;
    assign query_start  = item_accept && (item.command == CMD_QUERY);
    assign load_ok      = item_accept && (item.command == CMD_LOAD)
                          && (int'(item.entry_index) < TABLE_DEPTH);
    assign shift        = (state_reg == S_SCAN);
    assign push         = (state_reg == S_PUSH) && (!out_valid_reg || result.ready);

    // ring of cells, cell 0 presents the entry under scan
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam int NBR = (i == TABLE_DEPTH - 1) ? 0 : i + 1;

        ncs_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk    (clk),
            .load   (load_ok && (int'(item.entry_index) == i)),
            .shift  (shift),
            .load_x (item.coord_x),
            .load_y (item.coord_y),
            .nbr_x  (cell_x[NBR]),
            .nbr_y  (cell_y[NBR]),
            .x      (cell_x[i]),
            .y      (cell_y[i])
        );
    end

    always_comb
    begin
        ctrl.live     = shift;
        ctrl.first    = (step_reg == '0);
        ctrl.in_range = (int'(step_reg) < int'(cells_reg));
        ctrl.last     = (step_reg == IDX_W'(TABLE_DEPTH - 1));
    end

    ncs_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .idx      (step_reg),
        .cx       (cell_x[0]),
        .cy       (cell_y[0]),
        .px       (px_reg),
        .py       (py_reg),
        .limit    (limit_reg),
        .done     (dist_done),
        .best_idx (best_idx),
        .found    (best_found)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (query_start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (ctrl.last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (dist_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            cells_reg     <= CELLS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_DISTANCE_LIMIT: limit_reg <= cfg.data;
                    CFG_CELLS_IN_USE:   cells_reg <= cfg.data[COUNT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            px_reg <= item.coord_x;
            py_reg <= item.coord_y;
        end
        if (push)
        begin
            out_idx_reg   <= OUT_IDX_W'(best_idx);
            out_found_reg <= best_found;
        end
    end

    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.nearest_index = out_idx_reg;
    assign result.found         = out_found_reg;

endmodule

// File: hdl/ncs_checker.sv
`timescale 1ns / 1ps
`include "nearest_center_search_top_defines.svh"

module ncs_checker (
    input  logic      clk,
    input  logic      rst_n,
    ncs_in_if.sink    item,
    ncs_out_if.source result,
    ncs_cfg_if.sink   cfg
);
    import ncs_pkg::*;

    logic query_acc;
    assign query_acc = item.valid && item.ready && (item.command == CMD_QUERY);

    `NCS_ASSERT_CLK(a_result_held, clk, rst_n, result.valid && !result.ready |=> result.valid, "result dropped before taken")
    `NCS_ASSERT_CLK(a_miss_index_zero, clk, rst_n, result.valid && !result.found |-> result.nearest_index == '0, "index nonzero on miss")
    `NCS_ASSERT_CLK(a_busy_after_query, clk, rst_n, query_acc |=> !item.ready, "item taken during a scan")
    `NCS_ASSERT_CLK(a_no_instant_result, clk, rst_n, query_acc |=> !$rose(result.valid), "result too soon after query")
    `NCS_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg.ready || !rst_n, "cfg port stalled")

endmodule

bind nearest_center_search_top ncs_checker u_ncs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .result (result),
    .cfg    (cfg)
);
